FILE: rtl/ngga_pkg.sv
// Shared types, character codes and constants of the GGA position parser.
`timescale 1ns / 1ps

package ngga_pkg;

    // Field conversion limits
    localparam logic [3:0]  MAX_FIELD_CHARS = 4'd15;
    localparam logic [2:0]  FRACTION_DIGITS = 3'd4;
    localparam int          VALUE_W         = 30;
    localparam logic [29:0] SAT_VALUE       = 30'd999999999;

    // Header "GPGGA," is six characters long
    localparam logic [2:0]  HDR_LAST = 3'd5;

    // Character codes
    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_POINT  = 8'h2E;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;
    localparam logic [7:0] CH_G      = 8'h47;
    localparam logic [7:0] CH_P      = 8'h50;
    localparam logic [7:0] CH_A      = 8'h41;

    // Parse phases
    typedef enum logic [2:0] {
        PH_HUNT,
        PH_HEADER,
        PH_TIME,
        PH_LAT,
        PH_NS,
        PH_LON
    } t_phase;

    // Controls from the sequencer to the field converter and output stage
    typedef struct packed {
        logic field_clear;
        logic field_take;
        logic hold_lat;
        logic emit;
    } t_seq_ctl;

    // Powers of ten, clamped at 10^6
    function automatic logic [29:0] pow_ten(input logic [2:0] k);
        logic [29:0] p;
        unique case (k)
            3'd0:    p = 30'd1;
            3'd1:    p = 30'd10;
            3'd2:    p = 30'd100;
            3'd3:    p = 30'd1000;
            3'd4:    p = 30'd10000;
            3'd5:    p = 30'd100000;
            default: p = 30'd1000000;
        endcase
        return p;
    endfunction

    // Expected header character at each position
    function automatic logic [7:0] hdr_char(input logic [2:0] pos);
        logic [7:0] c;
        unique case (pos)
            3'd0:    c = CH_G;
            3'd1:    c = CH_P;
            3'd2:    c = CH_G;
            3'd3:    c = CH_G;
            3'd4:    c = CH_A;
            default: c = CH_COMMA;
        endcase
        return c;
    endfunction

    localparam logic [29:0] INT_SCALE = pow_ten(FRACTION_DIGITS);

endpackage

FILE: rtl/ngga_field.sv
// Decimal text to fixed-point converter for one sentence field.
`timescale 1ns / 1ps

module ngga_field (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  ngga_pkg::t_seq_ctl      i_ctl,
    input  logic [7:0]              i_byte,
    output logic [29:0]             o_value
);
    import ngga_pkg::*;

    logic [3:0]  r_cnt,      n_cnt;
    logic [29:0] r_acc,      n_acc;
    logic [2:0]  r_frac_cnt, n_frac_cnt;
    logic        r_point,    n_point;
    logic        r_stopped,  n_stopped;

    // Arithmetic for one digit
    logic        w_is_digit;
    logic [3:0]  w_digit;
    logic [2:0]  w_frac_idx;
    logic [33:0] w_int_val;
    logic [33:0] w_frac_val;

    assign w_is_digit = (i_byte >= CH_ZERO) && (i_byte <= CH_NINE);
    assign w_digit    = i_byte[3:0];
    assign w_frac_idx = FRACTION_DIGITS - 3'd1 - r_frac_cnt;
    assign w_int_val  = (34'(r_acc) << 3) + (34'(r_acc) << 1)
                      + 34'(w_digit) * 34'(INT_SCALE);
    assign w_frac_val = 34'(r_acc) + 34'(w_digit) * 34'(pow_ten(w_frac_idx));

    // Next field state
    always_comb begin
        n_cnt      = r_cnt;
        n_acc      = r_acc;
        n_frac_cnt = r_frac_cnt;
        n_point    = r_point;
        n_stopped  = r_stopped;
        if (i_ctl.field_clear) begin
            n_cnt      = '0;
            n_acc      = '0;
            n_frac_cnt = '0;
            n_point    = 1'b0;
            n_stopped  = 1'b0;
        end else if (i_ctl.field_take && (r_cnt < MAX_FIELD_CHARS)) begin
            n_cnt = r_cnt + 4'd1;
            if (!r_stopped) begin
                priority if ((i_byte == CH_POINT) && !r_point) begin
                    n_point = 1'b1;
                end else if (!w_is_digit) begin
                    n_stopped = 1'b1;
                end else if (!r_point) begin
                    n_acc = (w_int_val > 34'(SAT_VALUE)) ? SAT_VALUE : w_int_val[29:0];
                end else begin
                    // fraction digits past the kept ones are dropped
                    if (r_frac_cnt < FRACTION_DIGITS) begin
                        n_acc      = (w_frac_val > 34'(SAT_VALUE)) ? SAT_VALUE
                                                                   : w_frac_val[29:0];
                        n_frac_cnt = r_frac_cnt + 3'd1;
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt      <= '0;
            r_acc      <= '0;
            r_frac_cnt <= '0;
            r_point    <= 1'b0;
            r_stopped  <= 1'b0;
        end else begin
            r_cnt      <= n_cnt;
            r_acc      <= n_acc;
            r_frac_cnt <= n_frac_cnt;
            r_point    <= n_point;
            r_stopped  <= n_stopped;
        end
    end

    assign o_value = r_acc;

endmodule

FILE: rtl/ngga_seq.sv
// Sentence sequencer: dollar hunt, header match and field phases.
`timescale 1ns / 1ps

module ngga_seq (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_step,
    input  logic [7:0]              i_byte,
    output logic                    o_emit_req,
    output ngga_pkg::t_seq_ctl      o_ctl
);
    import ngga_pkg::*;

    t_phase     r_phase,   n_phase;
    logic [2:0] r_hdr_pos, n_hdr_pos;

    logic w_dollar;
    logic w_comma;

    assign w_dollar = (i_byte == CH_DOLLAR);
    assign w_comma  = (i_byte == CH_COMMA);

    // Result would be produced by this byte (ungated, used for stalling)
    assign o_emit_req = (r_phase == PH_LON) && w_comma;

    // Next phase
    always_comb begin
        n_phase   = r_phase;
        n_hdr_pos = r_hdr_pos;
        if (i_step) begin
            if (w_dollar) begin
                n_phase   = PH_HEADER;
                n_hdr_pos = '0;
            end else begin
                unique case (r_phase)
                    PH_HUNT: ;
                    PH_HEADER: begin
                        if (i_byte == hdr_char(r_hdr_pos)) begin
                            n_hdr_pos = r_hdr_pos + 3'd1;
                            if (r_hdr_pos == HDR_LAST) begin
                                n_phase = PH_TIME;
                            end
                        end else begin
                            n_phase = PH_HUNT;
                        end
                    end
                    PH_TIME: if (w_comma) n_phase = PH_LAT;
                    PH_LAT:  if (w_comma) n_phase = PH_NS;
                    PH_NS:   if (w_comma) n_phase = PH_LON;
                    PH_LON:  if (w_comma) n_phase = PH_HUNT;
                    default: n_phase = PH_HUNT;
                endcase
            end
        end
    end

    // Controls for this beat
    always_comb begin
        o_ctl = '0;
        if (i_step && !w_dollar) begin
            unique case (r_phase)
                PH_TIME, PH_NS: o_ctl.field_clear = w_comma;
                PH_LAT: begin
                    o_ctl.hold_lat   = w_comma;
                    o_ctl.field_take = !w_comma;
                end
                PH_LON: begin
                    o_ctl.emit       = w_comma;
                    o_ctl.field_take = !w_comma;
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_HUNT;
            r_hdr_pos <= '0;
        end else begin
            r_phase   <= n_phase;
            r_hdr_pos <= n_hdr_pos;
        end
    end

endmodule

FILE: rtl/nmea_gga_position_parser.sv
// A byte is registered on acceptance and parsed from that input register; the result
// for the comma that ends longitude is registered in the result register as it is parsed.
// Throughput: one byte per cycle; the input register only waits when a result is
// due and the output register still holds an untaken result.
// Reset (synchronous, active low) returns to dollar hunting and clears all field state.
`timescale 1ns / 1ps

module nmea_gga_position_parser (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [7:0]  i_rx_byte,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [29:0] o_latitude_e4,
    output logic [29:0] o_longitude_e4
);
    import ngga_pkg::*;

    logic        r_in_valid;
    logic [7:0]  r_in_byte;
    logic [29:0] r_held_lat;
    logic        r_out_valid;
    logic [29:0] r_out_lat;
    logic [29:0] r_out_lon;

    logic        w_step;
    logic        w_emit_req;
    logic [29:0] w_field_val;
    t_seq_ctl    w_ctl;

    // Parse the held byte unless its result cannot be stored yet
    assign w_step     = r_in_valid && (!w_emit_req || !r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || w_step;

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in_valid && o_in_ready) begin
            r_in_valid <= 1'b1;
        end else if (w_step) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_in_byte <= i_rx_byte;
        end
    end

    ngga_seq u_seq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_step     (w_step),
        .i_byte     (r_in_byte),
        .o_emit_req (w_emit_req),
        .o_ctl      (w_ctl)
    );

    ngga_field u_field (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_ctl),
        .i_byte  (r_in_byte),
        .o_value (w_field_val)
    );

    // Latitude kept until longitude ends
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held_lat <= '0;
        end else if (w_ctl.hold_lat) begin
            r_held_lat <= w_field_val;
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_ctl.emit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ctl.emit) begin
            r_out_lat <= r_held_lat;
            r_out_lon <= w_field_val;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_latitude_e4  = r_out_lat;
    assign o_longitude_e4 = r_out_lon;

    // A new result only follows a parsed comma
    a_emit_on_comma: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_in_byte) == CH_COMMA)
        else $error("result raised without a comma");

    // Delivered values never exceed the saturation point
    a_saturated: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out_lat <= SAT_VALUE) && (r_out_lon <= SAT_VALUE))
        else $error("result beyond saturation value");

    // A held byte that is not parsed is kept
    a_byte_kept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid && !w_step |=> r_in_valid && $stable(r_in_byte))
        else $error("held byte lost");

    // A result is never overwritten before it is taken
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_ctl.emit |-> !r_out_valid || i_out_ready)
        else $error("result overwritten");

endmodule
